/* hw/rtl/scds_pkg.sv */
// Shared types and constants for the serial clock divider solver.
// Used by scds_div and spi_clock_divider_solver_core; no dependencies.
package scds_pkg;

	localparam int DIV_W = 32;
	localparam int PS_W = 8;
	localparam int SPAN_LOG2 = 8;
	localparam logic [DIV_W-1:0] REF_CLK_RESET = 32'd50000000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV1,
		ST_PRESC,
		ST_DIV2,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic rem_nz;
	} div_stat_t;

endpackage

/* hw/rtl/scds_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on scds_pkg for widths and the request/status structs.
module scds_div import scds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_req_t         req,
	output div_stat_t        stat,
	output logic [DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign stat.busy   = busy_q;
	assign stat.done   = done_q;
	assign stat.rem_nz = |rem_q;
	assign quotient    = quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider done without a preceding busy cycle");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held longer than one cycle");

endmodule

/* hw/rtl/spi_clock_divider_solver_core.sv */
// Up to two serial divisions of 32 steps each on the shared divider:
// ceil(ref/rate) first, then ceil of that over the chosen prescale.
// An unreachable rate skips the second division, and a zero rate skips both.
// One request in flight; a result waits in ST_LOAD while the output stalls.
// Async active-low reset: FSM idle, output empty, reference clock back to 50 MHz.
// Depends on scds_pkg and scds_div.
module spi_clock_divider_solver_core import scds_pkg::*; #(
	parameter int PRESCALE_MAX = 254
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr_en,
	input  logic [DIV_W-1:0] cfg_wr_data,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [DIV_W-1:0] bit_rate,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [PS_W-1:0]  prescale,
	output logic [PS_W-1:0]  serial_rate_div,
	output logic             status
);

	localparam int Q_W = DIV_W + 1 - SPAN_LOG2;
	localparam logic [PS_W-1:0] PS_LAST = PS_W'(PRESCALE_MAX) & ~PS_W'(1);

	state_t           state_q, state_d;
	logic [DIV_W-1:0] ref_clk_q;
	logic [DIV_W-1:0] c_q;
	logic [PS_W-1:0]  ps_q;
	logic [PS_W-1:0]  div_q;
	logic             inval_q;
	logic             out_valid_q;
	logic [PS_W-1:0]  prescale_q;
	logic [PS_W-1:0]  srd_q;
	logic             status_q;

	div_req_t         dreq;
	div_stat_t        dstat;
	logic [DIV_W-1:0] quotient;

	logic [DIV_W:0]   c_rnd;
	logic [Q_W-1:0]   q;
	logic [Q_W:0]     ps_cand;
	logic             ps_ok;
	logic [PS_W+1:0]  need;
	logic             load_out;

	scds_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (dreq),
		.stat     (dstat),
		.quotient (quotient)
	);

	assign c_rnd   = {1'b0, c_q} + (DIV_W+1)'(2**SPAN_LOG2 - 1);
	assign q       = c_rnd[DIV_W:SPAN_LOG2];
	assign ps_cand = (q < Q_W'(2)) ? (Q_W+1)'(2) : ({1'b0, q} + (Q_W+1)'(q[0]));
	assign ps_ok   = ps_cand <= (Q_W+1)'(PS_LAST);
	assign need    = {1'b0, quotient[PS_W:0]} + (PS_W+2)'(dstat.rem_nz);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = (bit_rate == '0) ? ST_LOAD : ST_DIV1;
			end
			ST_DIV1: begin
				if (dstat.done) state_d = ST_PRESC;
			end
			ST_PRESC: begin
				state_d = ps_ok ? ST_DIV2 : ST_LOAD;
			end
			ST_DIV2: begin
				if (dstat.done) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		load_out      = 1'b0;
		dreq.start    = 1'b0;
		dreq.dividend = ref_clk_q;
		dreq.divisor  = bit_rate;
		case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				dreq.start = in_valid && (bit_rate != '0);
			end
			ST_PRESC: begin
				dreq.start    = ps_ok;
				dreq.dividend = c_q;
				dreq.divisor  = DIV_W'(ps_cand[PS_W-1:0]);
			end
			ST_LOAD: begin
				load_out = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ref_clk_q   <= REF_CLK_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) ref_clk_q <= cfg_wr_data;
			if (load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) inval_q <= (bit_rate == '0);
		if (state_q == ST_DIV1 && dstat.done) c_q <= quotient + DIV_W'(dstat.rem_nz);
		if (state_q == ST_PRESC) begin
			ps_q    <= ps_cand[PS_W-1:0];
			inval_q <= !ps_ok;
		end
		if (state_q == ST_DIV2 && dstat.done)
			div_q <= (need == '0) ? '0 : PS_W'(need - (PS_W+2)'(1));
		if (load_out) begin
			prescale_q <= inval_q ? '0 : ps_q;
			srd_q      <= inval_q ? '0 : div_q;
			status_q   <= inval_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign prescale        = prescale_q;
	assign serial_rate_div = srd_q;
	assign status          = status_q;

	a_inval_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (prescale == '0 && serial_rate_div == '0))
		else $error("invalid result with nonzero fields");

	a_ps_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !status) |->
		(!prescale[0] && prescale >= PS_W'(2) && prescale <= PS_LAST))
		else $error("prescale out of range");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.done |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
		else $error("divider done outside a division state");

	a_busy_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		dstat.busy |-> (state_q == ST_DIV1 || state_q == ST_DIV2))
		else $error("divider busy outside a division state");

endmodule
